// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the disk image parser.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/imd_pkg.sv =====
// Types and constants for the disk image parser.
// No dependencies.
package imd_pkg;

  localparam logic [7:0]  HdrTerm     = 8'h1a;
  localparam logic [7:0]  CylMapBit   = 8'h80;
  localparam logic [7:0]  HeadMapBit  = 8'h40;
  localparam logic [7:0]  MaxSizeCode = 8'd6;
  localparam logic [13:0] SecBase     = 14'd128;

  typedef enum logic [3:0] {
    PH_HDR   = 4'd0,
    PH_IGN   = 4'd1,
    PH_MODE  = 4'd2,
    PH_CYL   = 4'd3,
    PH_HEAD  = 4'd4,
    PH_COUNT = 4'd5,
    PH_SIZE  = 4'd6,
    PH_SMAP  = 4'd7,
    PH_CMAP  = 4'd8,
    PH_HMAP  = 4'd9,
    PH_REC   = 4'd10,
    PH_FILL  = 4'd11,
    PH_DATA  = 4'd12,
    PH_DEAD  = 4'd13
  } phase_e;

  typedef enum logic [4:0] {
    KIND_HDR_TEXT = 5'd0,
    KIND_HDR_END  = 5'd1,
    KIND_MODE     = 5'd2,
    KIND_CYL      = 5'd3,
    KIND_HEAD     = 5'd4,
    KIND_COUNT    = 5'd5,
    KIND_SIZE     = 5'd6,
    KIND_SMAP     = 5'd7,
    KIND_CMAP     = 5'd8,
    KIND_HMAP     = 5'd9,
    KIND_ABSENT   = 5'd10,
    KIND_NORMAL   = 5'd11,
    KIND_COMPRESS = 5'd12,
    KIND_DATA     = 5'd13,
    KIND_FILL     = 5'd14,
    KIND_IGNORED  = 5'd15,
    KIND_BAD_SIZE = 5'd16
  } kind_e;

endpackage

// ===== hdl/imd_disk_image_parser.sv =====
// Disk image parser: labels every byte of an ImageDisk image with one result.
// Each byte passes the input register, the parse FSM, then the result register.
// Throughput: one byte per cycle unless stalled; the parse FSM is single-step.
// Reset (rst_ni, async, active low) returns the parser to the header text phase,
// clears all counters and header_only, and empties both pipeline registers.
// Depends on imd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module imd_disk_image_parser
  import imd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_value_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  kind_o,
  output logic [7:0]  value_o,
  output logic [7:0]  sector_index_o,
  output logic [12:0] byte_offset_o,
  output logic [13:0] sector_bytes_o,
  output logic        last_of_sector_o
);

  // --------------------------------------------------------------------------
  // Pipeline control: the input register holds one byte until the result
  // register is free; a waiting result blocks input only while a byte is held there.
  // --------------------------------------------------------------------------
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       s1_adv;
  logic       in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload of the input register: hold while occupied and not moving on.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= byte_value_i;
    end
  end

  // --------------------------------------------------------------------------
  // Configuration: header_only is sampled when the header terminator is parsed.
  // --------------------------------------------------------------------------
  logic hdr_only_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_only_q <= 1'b0;
    end else if (cfg_we_i) begin
      hdr_only_q <= cfg_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Parse state
  // --------------------------------------------------------------------------
  phase_e      phase_q, phase_d;
  logic [1:0]  head_flags_q, head_flags_d;   // bit1 cylinder map, bit0 head map
  logic [7:0]  sec_count_q, sec_count_d;
  logic [2:0]  size_code_q, size_code_d;
  logic [7:0]  sec_cnt_q, sec_cnt_d;
  logic [7:0]  map_cnt_q, map_cnt_d;
  logic [12:0] data_cnt_q, data_cnt_d;

  logic [13:0] sec_bytes;
  logic        map_last;
  logic        sec_last;
  logic        data_last;
  logic        rec_fill;

  assign sec_bytes = SecBase << size_code_q;
  assign map_last  = ({1'b0, map_cnt_q} + 9'd1) >= {1'b0, sec_count_q};
  assign sec_last  = ({1'b0, sec_cnt_q} + 9'd1) >= {1'b0, sec_count_q};
  assign data_last = ({1'b0, data_cnt_q} + 14'd1) >= sec_bytes;
  assign rec_fill  = (s1_byte_q >= 8'd2) && (s1_byte_q <= 8'd8) && !s1_byte_q[0];

  // First map to walk from `from` on, else the records; next track if count is 0.
  function automatic phase_e first_map(phase_e from, logic [7:0] count, logic [1:0] flags);
    phase_e ph;
    if (count == 8'd0) begin
      ph = PH_MODE;
    end else if (from == PH_SMAP) begin
      ph = PH_SMAP;
    end else if (from == PH_CMAP && flags[1]) begin
      ph = PH_CMAP;
    end else if ((from == PH_CMAP || from == PH_HMAP) && flags[0]) begin
      ph = PH_HMAP;
    end else begin
      ph = PH_REC;
    end
    return ph;
  endfunction

  // Next state: advance only when the held byte moves into the result register.
  always_comb begin
    phase_d      = phase_q;
    head_flags_d = head_flags_q;
    sec_count_d  = sec_count_q;
    size_code_d  = size_code_q;
    sec_cnt_d    = sec_cnt_q;
    map_cnt_d    = map_cnt_q;
    data_cnt_d   = data_cnt_q;
    if (s1_adv) begin
      case (phase_q)
        PH_HDR: begin
          if (s1_byte_q == HdrTerm) begin
            phase_d = hdr_only_q ? PH_IGN : PH_MODE;
          end
        end
        PH_MODE:  phase_d = PH_CYL;
        PH_CYL:   phase_d = PH_HEAD;
        PH_HEAD: begin
          head_flags_d = {(s1_byte_q & CylMapBit) != 8'd0, (s1_byte_q & HeadMapBit) != 8'd0};
          phase_d      = PH_COUNT;
        end
        PH_COUNT: begin
          sec_count_d = s1_byte_q;
          phase_d     = PH_SIZE;
        end
        PH_SIZE: begin
          if (s1_byte_q > MaxSizeCode) begin
            phase_d = PH_DEAD;
          end else begin
            size_code_d = s1_byte_q[2:0];
            map_cnt_d   = 8'd0;
            phase_d     = first_map(PH_SMAP, sec_count_q, head_flags_q);
          end
        end
        PH_SMAP, PH_CMAP, PH_HMAP: begin
          if (map_last) begin
            map_cnt_d = 8'd0;
            case (phase_q)
              PH_SMAP: phase_d = first_map(PH_CMAP, sec_count_q, head_flags_q);
              PH_CMAP: phase_d = first_map(PH_HMAP, sec_count_q, head_flags_q);
              default: phase_d = first_map(PH_REC, sec_count_q, head_flags_q);
            endcase
            if (phase_d == PH_REC) begin
              sec_cnt_d = 8'd0;
            end
          end else begin
            map_cnt_d = map_cnt_q + 8'd1;
          end
        end
        PH_REC: begin
          if (s1_byte_q == 8'd0) begin
            sec_cnt_d = sec_last ? 8'd0 : sec_cnt_q + 8'd1;
            phase_d   = sec_last ? PH_MODE : PH_REC;
          end else if (rec_fill) begin
            phase_d = PH_FILL;
          end else begin
            data_cnt_d = 13'd0;
            phase_d    = PH_DATA;
          end
        end
        PH_FILL: begin
          sec_cnt_d = sec_last ? 8'd0 : sec_cnt_q + 8'd1;
          phase_d   = sec_last ? PH_MODE : PH_REC;
        end
        PH_DATA: begin
          if (data_last) begin
            data_cnt_d = 13'd0;
            sec_cnt_d  = sec_last ? 8'd0 : sec_cnt_q + 8'd1;
            phase_d    = sec_last ? PH_MODE : PH_REC;
          end else begin
            data_cnt_d = data_cnt_q + 13'd1;
          end
        end
        default: phase_d = phase_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HDR;
      head_flags_q <= 2'd0;
      sec_count_q  <= 8'd0;
      size_code_q  <= 3'd0;
      sec_cnt_q    <= 8'd0;
      map_cnt_q    <= 8'd0;
      data_cnt_q   <= 13'd0;
    end else begin
      phase_q      <= phase_d;
      head_flags_q <= head_flags_d;
      sec_count_q  <= sec_count_d;
      size_code_q  <= size_code_d;
      sec_cnt_q    <= sec_cnt_d;
      map_cnt_q    <= map_cnt_d;
      data_cnt_q   <= data_cnt_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result fields for the held byte
  // --------------------------------------------------------------------------
  kind_e       kind_d;
  logic [7:0]  idx_d;
  logic [12:0] off_d;
  logic [13:0] bytes_d;
  logic        last_d;

  always_comb begin
    kind_d  = KIND_IGNORED;
    idx_d   = 8'd0;
    off_d   = 13'd0;
    bytes_d = 14'd0;
    last_d  = 1'b0;
    case (phase_q)
      PH_HDR:   kind_d = (s1_byte_q == HdrTerm) ? KIND_HDR_END : KIND_HDR_TEXT;
      PH_MODE:  kind_d = KIND_MODE;
      PH_CYL:   kind_d = KIND_CYL;
      PH_HEAD:  kind_d = KIND_HEAD;
      PH_COUNT: kind_d = KIND_COUNT;
      PH_SIZE: begin
        if (s1_byte_q > MaxSizeCode) begin
          kind_d = KIND_BAD_SIZE;
        end else begin
          kind_d  = KIND_SIZE;
          bytes_d = SecBase << s1_byte_q[2:0];
        end
      end
      PH_SMAP, PH_CMAP, PH_HMAP: begin
        case (phase_q)
          PH_SMAP: kind_d = KIND_SMAP;
          PH_CMAP: kind_d = KIND_CMAP;
          default: kind_d = KIND_HMAP;
        endcase
        idx_d   = map_cnt_q;
        bytes_d = sec_bytes;
      end
      PH_REC: begin
        idx_d   = sec_cnt_q;
        bytes_d = sec_bytes;
        if (s1_byte_q == 8'd0) begin
          kind_d = KIND_ABSENT;
        end else if (rec_fill) begin
          kind_d = KIND_COMPRESS;
        end else begin
          kind_d = KIND_NORMAL;
        end
      end
      PH_FILL: begin
        kind_d  = KIND_FILL;
        idx_d   = sec_cnt_q;
        bytes_d = sec_bytes;
        last_d  = 1'b1;
      end
      PH_DATA: begin
        kind_d  = KIND_DATA;
        idx_d   = sec_cnt_q;
        bytes_d = sec_bytes;
        off_d   = data_cnt_q;
        last_d  = data_last;
      end
      default: kind_d = KIND_IGNORED;
    endcase
  end

  // Result register: load on advance, hold while stalled.
  logic [4:0]  kind_q;
  logic [7:0]  value_q;
  logic [7:0]  idx_q;
  logic [12:0] off_q;
  logic [13:0] bytes_q;
  logic        last_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      kind_q  <= kind_d;
      value_q <= s1_byte_q;
      idx_q   <= idx_d;
      off_q   <= off_d;
      bytes_q <= bytes_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign value_o          = value_q;
  assign sector_index_o   = idx_q;
  assign byte_offset_o    = off_q;
  assign sector_bytes_o   = bytes_q;
  assign last_of_sector_o = last_q;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  // A bad size code locks the parser until reset.
  `ASSERT_NEXT(a_dead_sticks, clk_i, rst_ni, phase_q == PH_DEAD, phase_q == PH_DEAD)
  // Every fill result closes its sector.
  `ASSERT_IMPLY(a_fill_last, clk_i, rst_ni, out_valid_q && kind_q == KIND_FILL, last_q)
  // A data offset always lies inside the sector.
  `ASSERT_IMPLY(a_off_range, clk_i, rst_ni, out_valid_q && kind_q == KIND_DATA,
                {1'b0, off_q} < bytes_q)
  // Stall the input only while a byte is held waiting for the result register.
  `ASSERT_IMPLY(a_stall_held, clk_i, rst_ni, in_stall_o, s1_valid_q && out_valid_q)

endmodule

// ===== sim/imd_label_checker.sv =====
// Result checker for the disk image parser: predicts the label of every byte.
// Watches both channels and the configuration port, compares each result transfer.
// Depends on imd_pkg.
module imd_label_checker
  import imd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  byte_value_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [4:0]  kind_i,
  input  logic [7:0]  value_i,
  input  logic [7:0]  sector_index_i,
  input  logic [12:0] byte_offset_i,
  input  logic [13:0] sector_bytes_i,
  input  logic        last_of_sector_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  value;
    logic [7:0]  sector_index;
    logic [12:0] byte_offset;
    logic [13:0] sector_bytes;
    logic        last;
  } byte_label_t;

  // parser state as the block should hold it
  logic        header_only;
  phase_e      phase;
  logic [1:0]  head_flags;
  logic [7:0]  sector_count;
  logic [2:0]  size_code;
  logic [7:0]  sector_counter;
  logic [7:0]  map_counter;
  logic [13:0] data_counter;

  byte_label_t expected_labels [$];
  byte_label_t want;
  byte_label_t seen;
  int unsigned failures = 0;
  int unsigned outstanding = 0;

  assign fail_count_o = failures;
  assign pending_o    = outstanding;

  // Open the next present map, else the records; with no sectors, the next track.
  task automatic enter_map(input phase_e target);
    map_counter = '0;
    if (sector_count == 8'd0) begin
      phase = PH_MODE;
    end else if (target == PH_SMAP) begin
      phase = PH_SMAP;
    end else if (target == PH_CMAP && head_flags[1]) begin
      phase = PH_CMAP;
    end else if ((target == PH_CMAP || target == PH_HMAP) && head_flags[0]) begin
      phase = PH_HMAP;
    end else begin
      sector_counter = '0;
      phase = PH_REC;
    end
  endtask

  task automatic advance_sector();
    if (int'(sector_counter) + 1 >= int'(sector_count)) begin
      phase = PH_MODE;
      sector_counter = '0;
    end else begin
      sector_counter = sector_counter + 8'd1;
      phase = PH_REC;
    end
  endtask

  task automatic label_byte(input logic [7:0] b, output byte_label_t r);
    logic [13:0] len;
    phase_e      nxt;
    len = SecBase << size_code;
    r = '0;
    r.kind = KIND_IGNORED;
    r.value = b;
    case (phase)
      PH_HDR: begin
        if (b == HdrTerm) begin
          r.kind = KIND_HDR_END;
          phase = header_only ? PH_IGN : PH_MODE;
        end else begin
          r.kind = KIND_HDR_TEXT;
        end
      end
      PH_MODE: begin
        r.kind = KIND_MODE;
        phase = PH_CYL;
      end
      PH_CYL: begin
        r.kind = KIND_CYL;
        phase = PH_HEAD;
      end
      PH_HEAD: begin
        r.kind = KIND_HEAD;
        head_flags = {|(b & CylMapBit), |(b & HeadMapBit)};
        phase = PH_COUNT;
      end
      PH_COUNT: begin
        r.kind = KIND_COUNT;
        sector_count = b;
        phase = PH_SIZE;
      end
      PH_SIZE: begin
        if (b > MaxSizeCode) begin
          r.kind = KIND_BAD_SIZE;
          phase = PH_DEAD;
        end else begin
          r.kind = KIND_SIZE;
          size_code = b[2:0];
          r.sector_bytes = SecBase << b[2:0];
          enter_map(PH_SMAP);
        end
      end
      PH_SMAP, PH_CMAP, PH_HMAP: begin
        if (phase == PH_SMAP) begin
          r.kind = KIND_SMAP;
          nxt = PH_CMAP;
        end else if (phase == PH_CMAP) begin
          r.kind = KIND_CMAP;
          nxt = PH_HMAP;
        end else begin
          r.kind = KIND_HMAP;
          nxt = PH_REC;
        end
        r.sector_index = map_counter;
        r.sector_bytes = len;
        if (int'(map_counter) + 1 >= int'(sector_count)) begin
          enter_map(nxt);
        end else begin
          map_counter = map_counter + 8'd1;
        end
      end
      PH_REC: begin
        r.sector_index = sector_counter;
        r.sector_bytes = len;
        if (b == 8'd0) begin
          r.kind = KIND_ABSENT;
          advance_sector();
        end else if (b >= 8'd2 && b <= 8'd8 && !b[0]) begin
          r.kind = KIND_COMPRESS;
          phase = PH_FILL;
        end else begin
          r.kind = KIND_NORMAL;
          data_counter = '0;
          phase = PH_DATA;
        end
      end
      PH_FILL: begin
        r.kind = KIND_FILL;
        r.sector_index = sector_counter;
        r.sector_bytes = len;
        r.last = 1'b1;
        advance_sector();
      end
      PH_DATA: begin
        r.kind = KIND_DATA;
        r.sector_index = sector_counter;
        r.sector_bytes = len;
        r.byte_offset = data_counter[12:0];
        if (int'(data_counter) + 1 >= int'(len)) begin
          r.last = 1'b1;
          data_counter = '0;
          advance_sector();
        end else begin
          data_counter = data_counter + 14'd1;
        end
      end
      default: r.kind = KIND_IGNORED;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_labels.delete();
      outstanding <= 0;
      header_only = 1'b0;
      phase = PH_HDR;
      head_flags = '0;
      sector_count = '0;
      size_code = '0;
      sector_counter = '0;
      map_counter = '0;
      data_counter = '0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        label_byte(byte_value_i, want);
        expected_labels.push_back(want);
      end
      if (cfg_we_i) begin
        header_only = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        seen.kind = kind_e'(kind_i);
        seen.value = value_i;
        seen.sector_index = sector_index_i;
        seen.byte_offset = byte_offset_i;
        seen.sector_bytes = sector_bytes_i;
        seen.last = last_of_sector_i;
        if (expected_labels.size() == 0) begin
          failures++;
          if (failures <= 10) begin
            $display("unexpected result: kind %0d value %02h idx %0d off %0d bytes %0d last %0b",
                     seen.kind, seen.value, seen.sector_index, seen.byte_offset,
                     seen.sector_bytes, seen.last);
          end
        end else begin
          want = expected_labels.pop_front();
          if (seen.kind !== want.kind || seen.value !== want.value ||
              seen.sector_index !== want.sector_index ||
              seen.byte_offset !== want.byte_offset ||
              seen.sector_bytes !== want.sector_bytes || seen.last !== want.last) begin
            failures++;
            if (failures <= 10) begin
              $display("mismatch: want kind %0d value %02h idx %0d off %0d bytes %0d last %0b",
                       want.kind, want.value, want.sector_index, want.byte_offset,
                       want.sector_bytes, want.last);
              $display("          got  kind %0d value %02h idx %0d off %0d bytes %0d last %0b",
                       seen.kind, seen.value, seen.sector_index, seen.byte_offset,
                       seen.sector_bytes, seen.last);
            end
          end
        end
      end
      outstanding <= expected_labels.size();
    end
  end

endmodule

// ===== sim/imd_disk_image_parser_test.sv =====
// Testbench top for imd_disk_image_parser: feeds a disk image byte stream and gives the verdict.
// Depends on imd_pkg, imd_disk_image_parser and imd_label_checker (sim/imd_label_checker.sv).
module imd_disk_image_parser_test;
  import imd_pkg::*;

  localparam int unsigned QuietLimit   = 2000;  // cycles without any transfer
  localparam int unsigned RxHoldCycles = 300;   // long receiver hold-off

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_data_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  byte_value_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [4:0]  kind_o;
  logic [7:0]  value_o;
  logic [7:0]  sector_index_o;
  logic [12:0] byte_offset_o;
  logic [13:0] sector_bytes_o;
  logic        last_of_sector_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned bytes_sent = 0;
  int unsigned quiet_cycles = 0;

  // calm flags switch off idling on one side for a stretch of tracks
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  bit rx_hold_req = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  imd_disk_image_parser dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .byte_value_i     (byte_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .value_o          (value_o),
    .sector_index_o   (sector_index_o),
    .byte_offset_o    (byte_offset_o),
    .sector_bytes_o   (sector_bytes_o),
    .last_of_sector_o (last_of_sector_o)
  );

  imd_label_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .byte_value_i     (byte_value_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_i           (kind_o),
    .value_i          (value_o),
    .sector_index_i   (sector_index_o),
    .byte_offset_i    (byte_offset_o),
    .sector_bytes_i   (sector_bytes_o),
    .last_of_sector_i (last_of_sector_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // Offer one byte after a random gap and hold it until the transfer.
  // Signals are sampled just after the edge, so they still show the values at the edge.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_value_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Drop valid and wait until every byte sent so far has had its result.
  // The first edge lets the count take in the last transfer.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_header_only(input logic v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One well-formed track record with random content. Full sector data is
  // only sent for the two smallest sizes; one_big_sector forces a fill record.
  task automatic send_track(input logic [7:0] count, input logic [2:0] size,
                            input logic [7:0] head, input bit one_big_sector);
    int unsigned pick;
    logic [7:0]  rec;
    send_byte(8'($urandom));
    send_byte(8'($urandom));
    send_byte(head);
    send_byte(count);
    send_byte({5'd0, size});
    repeat (count) send_byte(8'($urandom));
    if ((head & CylMapBit) != 0) begin
      repeat (count) send_byte(8'($urandom));
    end
    if ((head & HeadMapBit) != 0) begin
      repeat (count) send_byte(8'($urandom));
    end
    for (int s = 0; s < int'(count); s++) begin
      pick = one_big_sector ? 4 : $urandom_range(0, 9);
      if (pick < 3) begin
        rec = 8'h00;
      end else if (pick < 6 || (size > 3'd1 && !one_big_sector)) begin
        rec = 8'(2 * $urandom_range(1, 4));
      end else begin
        case ($urandom_range(0, 2))
          0: rec = 8'h01;
          1: rec = 8'(2 * $urandom_range(1, 3) + 1);
          default: rec = 8'($urandom_range(9, 255));
        endcase
      end
      send_byte(rec);
      if (rec != 8'h00 && rec <= 8'h08 && !rec[0]) begin
        send_byte(8'($urandom));
      end else if (rec != 8'h00) begin
        repeat (SecBase << size) send_byte(8'($urandom));
      end
    end
  endtask

  // Receiver: stall for a random gap before each result, or hold off
  // for a long stretch on request so that the block backs up to its input.
  initial begin
    int unsigned hold;
    forever begin
      if (rx_hold_req) begin
        hold = RxHoldCycles;
        rx_hold_req = 1'b0;
      end else begin
        hold = rx_calm ? 0 : $urandom_range(0, 4);
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Watchdog: end the run when nothing has moved on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [7:0]  text_bytes [0:4];
    logic [7:0]  first_tracks [0:18];
    int unsigned track_no;
    logic [7:0]  count;
    logic [2:0]  size;
    text_bytes = '{8'h00, 8'hff, 8'h49, 8'h4d, 8'h44};
    // Both maps, an absent and a compressed record, then a zero-sector
    // track with the largest size code.
    first_tracks = '{8'h00, 8'hff, 8'hc0, 8'h02, 8'h00,
                     8'h01, 8'h02, 8'hff, 8'h00, 8'h01, 8'h00,
                     8'h00, 8'h08, 8'he5,
                     8'h05, 8'h00, 8'h3f, 8'h00, 8'h06};
    track_no = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Toggle the header-only bit while in the header; leave it clear at the
    // terminator so that the track records are parsed.
    write_header_only(1'b1);
    for (int i = 0; i < 3; i++) send_byte(text_bytes[i]);
    write_header_only(1'b0);
    for (int i = 3; i < 5; i++) send_byte(text_bytes[i]);
    send_byte(HdrTerm);
    foreach (first_tracks[i]) send_byte(first_tracks[i]);

    // Random tracks, mostly small; the bit written now must have no effect.
    while (bytes_sent < 200) begin
      if (track_no % 5 == 0) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
      end
      if (track_no == 0) begin
        rx_hold_req = 1'b1;
      end
      count = 8'($urandom_range(0, 9) == 0 ? $urandom_range(4, 12) : $urandom_range(0, 3));
      size = 3'($urandom_range(0, 5) == 0 ? $urandom_range(2, 6) : $urandom_range(0, 1));
      send_track(count, size, 8'($urandom), 1'b0);
      if (track_no % 4 == 3) begin
        write_header_only(1'($urandom_range(0, 1)));
      end
      track_no++;
    end

    // Largest sector count, then one fill record of the largest size.
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    send_track(8'd255, 3'd2, HeadMapBit, 1'b0);
    send_track(8'd1, 3'd6, 8'h00, 1'b1);
    write_header_only(1'b1);

    // Bad size code ends parsing; everything after it is ignored.
    repeat (4) send_byte(8'($urandom));
    send_byte($urandom_range(0, 1) ? 8'd7 : 8'($urandom_range(8, 255)));
    repeat (12) send_byte(8'($urandom));

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
